@@ src/cd_sector_error_statistics_defines.svh @@
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CD_SECTOR_ERROR_STATISTICS_DEFINES_SVH
`define CD_SECTOR_ERROR_STATISTICS_DEFINES_SVH

// Implication into the next cycle, off while reset is high.
`define CDSES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdses check failed");

// Implication into the next cycle, also checked across reset.
`define CDSES_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cdses check failed");

`endif

@@ src/cdses_pkg.sv @@
`timescale 1ns / 1ps

package cdses_pkg;

  localparam logic [3:0]  RECOVERED_KEY = 4'h1;
  localparam logic [23:0] MAX24         = 24'hFF_FFFF;
  localparam logic [31:0] MAX32         = 32'hFFFF_FFFF;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 288;

  typedef logic [23:0] cnt24_t;
  typedef logic [31:0] cnt32_t;
  typedef logic [15:0] val16_t;

  // saturating increment of a 24-bit counter
  function automatic cnt24_t inc24(input cnt24_t a);
    inc24 = (a == MAX24) ? MAX24 : a + 24'd1;
  endfunction

  function automatic cnt24_t add24(input cnt24_t a, input val16_t b);
    logic [24:0] s;
    s = {1'b0, a} + {9'd0, b};
    add24 = s[24] ? MAX24 : s[23:0];
  endfunction

  function automatic cnt32_t add32(input cnt32_t a, input val16_t b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    add32 = s[32] ? MAX32 : s[31:0];
  endfunction

endpackage

@@ src/cd_sector_error_statistics.sv @@
`timescale 1ns / 1ps

// CD sector error statistics.
// Input stream: one beat per scanned sector. s_tuser[0] is start_scan, which
// clears all statistics before the sector is counted. s_tdata carries the
// sector report (address, read status, sense key, C2 pointer bits, C1 and C2
// block counts).
// Output stream: one beat per sector with the statistics after that sector.
// Config channel: cfg_data is c1_enabled, written on cfg_valid (always ready).
// Write it only while no sector is in flight.
// Latency: the result beat is valid the cycle after the input beat is taken.
// Throughput: one sector per cycle while the output is not stalled. The statistics
// registers double as the output register, so the whole update is combinational.
// Reset: all statistics and the second counter clear, c1_enabled goes to 1,
// the output goes empty.
// Stall: while a result waits with m_tready low, it holds and s_tready drops; a new
// input beat is taken in the same cycle the held result leaves.
module cd_sector_error_statistics #(
  parameter int SECTORS_PER_SECOND = 75
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // [23:0] sector_address, [24] read_ok, [28:25] sense_key,
  // [40:29] c2_pointer_bits, [56:41] c1_block_count, [72:57] c2_block_count,
  // [79:73] zero
  input  logic [cdses_pkg::IN_DATA_W-1:0] s_tdata,
  // [0] start_scan
  input  logic [0:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // [31:0] c1_total, [55:32] c1_sector_count, [71:56] c1_sector_peak,
  // [95:72] c1_second_peak, [127:96] c2_total, [151:128] c2_sector_count,
  // [167:152] c2_sector_peak, [191:168] c2_peak_address,
  // [215:192] c2_second_peak, [239:216] c2_second_address,
  // [263:240] read_failure_count, [287:264] longest_error_run
  output logic [cdses_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  localparam int SecW = (SECTORS_PER_SECOND > 1) ? $clog2(SECTORS_PER_SECOND) : 1;
  localparam logic [SecW:0] SpsCount = (SecW+1)'(SECTORS_PER_SECOND);

  logic accept;

  logic                 c1_enabled;
  logic [SecW-1:0]      sector_in_second, sector_in_second_next;
  cdses_pkg::cnt24_t    second_start, second_start_next;
  cdses_pkg::cnt24_t    second_c1_sum, second_c1_sum_next;
  cdses_pkg::cnt24_t    second_c2_sum, second_c2_sum_next;
  cdses_pkg::cnt24_t    current_run, current_run_next;
  cdses_pkg::cnt32_t    c1_total, c1_total_next;
  cdses_pkg::cnt32_t    c2_total, c2_total_next;
  cdses_pkg::cnt24_t    c1_sector_count, c1_sector_count_next;
  cdses_pkg::val16_t    c1_sector_peak, c1_sector_peak_next;
  cdses_pkg::cnt24_t    c1_second_peak, c1_second_peak_next;
  cdses_pkg::cnt24_t    c2_sector_count, c2_sector_count_next;
  cdses_pkg::val16_t    c2_sector_peak, c2_sector_peak_next;
  cdses_pkg::cnt24_t    c2_peak_address, c2_peak_address_next;
  cdses_pkg::cnt24_t    c2_second_peak, c2_second_peak_next;
  cdses_pkg::cnt24_t    c2_second_address, c2_second_address_next;
  cdses_pkg::cnt24_t    read_failure_count, read_failure_count_next;
  cdses_pkg::cnt24_t    longest_error_run, longest_error_run_next;

  // input fields
  logic                 start_scan;
  cdses_pkg::cnt24_t    sector_address;
  logic                 read_ok;
  logic [3:0]           sense_key;
  logic [11:0]          c2_pointer_bits;
  cdses_pkg::val16_t    c1_block_count;
  cdses_pkg::val16_t    c2_block_count;

  cdses_pkg::val16_t    c1_val, c2b_val, c2_eff;
  logic                 second_first, c1_hit, c2_hit, run_extend;
  logic [SecW:0]        sec_inc;

  assign start_scan      = s_tuser[0];
  assign sector_address  = s_tdata[23:0];
  assign read_ok         = s_tdata[24];
  assign sense_key       = s_tdata[28:25];
  assign c2_pointer_bits = s_tdata[40:29];
  assign c1_block_count  = s_tdata[56:41];
  assign c2_block_count  = s_tdata[72:57];

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tdata = {longest_error_run, read_failure_count, c2_second_address,
                    c2_second_peak, c2_peak_address, c2_sector_peak,
                    c2_sector_count, c2_total, c1_second_peak, c1_sector_peak,
                    c1_sector_count, c1_total};

  always_comb begin
    // start of scan: work from cleared statistics
    sector_in_second_next   = start_scan ? '0 : sector_in_second;
    second_start_next       = start_scan ? '0 : second_start;
    second_c1_sum_next      = start_scan ? '0 : second_c1_sum;
    second_c2_sum_next      = start_scan ? '0 : second_c2_sum;
    current_run_next        = start_scan ? '0 : current_run;
    c1_total_next           = start_scan ? '0 : c1_total;
    c2_total_next           = start_scan ? '0 : c2_total;
    c1_sector_count_next    = start_scan ? '0 : c1_sector_count;
    c1_sector_peak_next     = start_scan ? '0 : c1_sector_peak;
    c1_second_peak_next     = start_scan ? '0 : c1_second_peak;
    c2_sector_count_next    = start_scan ? '0 : c2_sector_count;
    c2_sector_peak_next     = start_scan ? '0 : c2_sector_peak;
    c2_peak_address_next    = start_scan ? '0 : c2_peak_address;
    c2_second_peak_next     = start_scan ? '0 : c2_second_peak;
    c2_second_address_next  = start_scan ? '0 : c2_second_address;
    read_failure_count_next = start_scan ? '0 : read_failure_count;
    longest_error_run_next  = start_scan ? '0 : longest_error_run;

    c1_val  = c1_enabled ? c1_block_count : '0;
    c2b_val = c1_enabled ? c2_block_count : '0;
    c2_eff  = ({4'd0, c2_pointer_bits} > c2b_val) ? {4'd0, c2_pointer_bits} : c2b_val;

    second_first = (sector_in_second_next == '0);
    if (second_first) begin
      second_start_next  = sector_address;
      second_c1_sum_next = '0;
      second_c2_sum_next = '0;
    end

    c1_hit     = read_ok && (c1_val != '0);
    c2_hit     = read_ok && (c2_eff != '0) && (sense_key != cdses_pkg::RECOVERED_KEY);
    run_extend = !read_ok || c2_hit;

    if (c1_hit) begin
      c1_total_next        = cdses_pkg::add32(c1_total_next, c1_val);
      c1_sector_count_next = cdses_pkg::inc24(c1_sector_count_next);
      second_c1_sum_next   = cdses_pkg::add24(second_c1_sum_next, c1_val);
      if (c1_val > c1_sector_peak_next) begin
        c1_sector_peak_next = c1_val;
      end
      if (second_c1_sum_next > c1_second_peak_next) begin
        c1_second_peak_next = second_c1_sum_next;
      end
    end

    if (c2_hit) begin
      c2_total_next        = cdses_pkg::add32(c2_total_next, c2_eff);
      c2_sector_count_next = cdses_pkg::inc24(c2_sector_count_next);
      second_c2_sum_next   = cdses_pkg::add24(second_c2_sum_next, c2_eff);
      if (c2_eff > c2_sector_peak_next) begin
        c2_sector_peak_next  = c2_eff;
        c2_peak_address_next = sector_address;
      end
      if (second_c2_sum_next > c2_second_peak_next) begin
        c2_second_peak_next    = second_c2_sum_next;
        c2_second_address_next = second_start_next;
      end
    end

    if (!read_ok) begin
      read_failure_count_next = cdses_pkg::inc24(read_failure_count_next);
    end

    if (run_extend) begin
      current_run_next = cdses_pkg::inc24(current_run_next);
      if (current_run_next > longest_error_run_next) begin
        longest_error_run_next = current_run_next;
      end
    end else begin
      current_run_next = '0;
    end

    // advance the position inside the current second
    sec_inc = {1'b0, sector_in_second_next} + {{SecW{1'b0}}, 1'b1};
    sector_in_second_next = (sec_inc >= SpsCount) ? '0 : sec_inc[SecW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid           <= 1'b0;
      c1_enabled         <= 1'b1;
      sector_in_second   <= '0;
      second_start       <= '0;
      second_c1_sum      <= '0;
      second_c2_sum      <= '0;
      current_run        <= '0;
      c1_total           <= '0;
      c2_total           <= '0;
      c1_sector_count    <= '0;
      c1_sector_peak     <= '0;
      c1_second_peak     <= '0;
      c2_sector_count    <= '0;
      c2_sector_peak     <= '0;
      c2_peak_address    <= '0;
      c2_second_peak     <= '0;
      c2_second_address  <= '0;
      read_failure_count <= '0;
      longest_error_run  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        c1_enabled <= cfg_data;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        sector_in_second   <= sector_in_second_next;
        second_start       <= second_start_next;
        second_c1_sum      <= second_c1_sum_next;
        second_c2_sum      <= second_c2_sum_next;
        current_run        <= current_run_next;
        c1_total           <= c1_total_next;
        c2_total           <= c2_total_next;
        c1_sector_count    <= c1_sector_count_next;
        c1_sector_peak     <= c1_sector_peak_next;
        c1_second_peak     <= c1_second_peak_next;
        c2_sector_count    <= c2_sector_count_next;
        c2_sector_peak     <= c2_sector_peak_next;
        c2_peak_address    <= c2_peak_address_next;
        c2_second_peak     <= c2_second_peak_next;
        c2_second_address  <= c2_second_address_next;
        read_failure_count <= read_failure_count_next;
        longest_error_run  <= longest_error_run_next;
      end
    end
  end

endmodule

@@ src/cdses_checker.sv @@
`timescale 1ns / 1ps
`include "cd_sector_error_statistics_defines.svh"

module cdses_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [0:0] s_tuser,
  input logic m_tvalid,
  input logic m_tready,
  input logic [cdses_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic        in_beat;
  logic        in_cont;
  logic [23:0] longest_run;

  assign in_beat     = s_tvalid && s_tready;
  assign in_cont     = in_beat && !s_tuser[0];
  assign longest_run = m_tdata[287:264];

  // output beat holds while stalled
  `CDSES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // reset empties the output
  `CDSES_ASSERT_NEXT_ANY(a_rst_empty, rst, !m_tvalid)

  // every taken sector yields a result beat next cycle
  `CDSES_ASSERT_NEXT(a_in_to_out, in_beat, m_tvalid)

  // longest run never shrinks without a start of scan
  `CDSES_ASSERT_NEXT(a_run_mono, in_cont, longest_run >= $past(longest_run))

endmodule

bind cd_sector_error_statistics cdses_checker u_cdses_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

@@ verif/tb_cd_sector_error_statistics.sv @@
`timescale 1ns / 1ps

module tb_cd_sector_error_statistics;

  localparam int SECTORS_PER_SECOND = 75;
  localparam int IN_W = cdses_pkg::IN_DATA_W;
  localparam int OUT_W = cdses_pkg::OUT_DATA_W;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_OFF_AT = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [3:0] RECOVERED_KEY = cdses_pkg::RECOVERED_KEY;
  localparam logic [3:0] NO_SENSE = 4'h0;
  localparam logic [23:0] SAT24 = cdses_pkg::MAX24;
  localparam logic [31:0] SAT32 = cdses_pkg::MAX32;

  // s_tdata layout, MSB first
  typedef struct packed {
    logic [15:0] c2_block_count;
    logic [15:0] c1_block_count;
    logic [11:0] c2_pointer_bits;
    logic [3:0]  sense_key;
    logic        read_ok;
    logic [23:0] sector_address;
  } sector_rep_t;

  typedef struct packed {
    logic        start_scan;
    sector_rep_t rep;
  } sector_beat_t;

  // m_tdata layout, MSB first
  typedef struct packed {
    logic [23:0] longest_error_run;
    logic [23:0] read_failure_count;
    logic [23:0] c2_second_address;
    logic [23:0] c2_second_peak;
    logic [23:0] c2_peak_address;
    logic [15:0] c2_sector_peak;
    logic [23:0] c2_sector_count;
    logic [31:0] c2_total;
    logic [23:0] c1_second_peak;
    logic [15:0] c1_sector_peak;
    logic [23:0] c1_sector_count;
    logic [31:0] c1_total;
  } sector_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  sector_beat_t pending_sectors[$];
  sector_stats_t expected_stats[$];

  // statistics tracker state
  logic          c1_enable_model;
  logic [6:0]    second_pos;
  logic [23:0]   second_base;
  logic [23:0]   second_c1;
  logic [23:0]   second_c2;
  logic [23:0]   run_len;
  sector_stats_t tally;

  int cycle_cnt = 0;
  int sectors_in = 0;
  int mismatches = 0;
  logic in_taken = 1'b0;
  sector_stats_t got_stats;
  sector_stats_t want_stats;

  logic src_idle_on = 1'b1;
  logic snk_idle_on = 1'b1;
  int src_gap = 0;
  int sink_stall = 0;
  logic hold_off_done = 1'b0;
  int burst_left = 0;
  sector_beat_t next_beat;

  always #4 clk = ~clk;

  cd_sector_error_statistics #(
    .SECTORS_PER_SECOND(SECTORS_PER_SECOND)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic logic [23:0] sat_add24(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[24] ? SAT24 : s[23:0];
  endfunction

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

  function automatic void clear_tallies();
    second_pos = '0;
    second_base = '0;
    second_c1 = '0;
    second_c2 = '0;
    run_len = '0;
    tally = '0;
  endfunction

  function automatic void lengthen_run();
    run_len = sat_add24(run_len, 24'd1);
    if (run_len > tally.longest_error_run) tally.longest_error_run = run_len;
  endfunction

  function automatic sector_stats_t count_sector(logic start, sector_rep_t r);
    logic [15:0] c1;
    logic [15:0] c2b;
    logic [15:0] eff;
    if (start) clear_tallies();
    c1 = c1_enable_model ? r.c1_block_count : 16'd0;
    c2b = c1_enable_model ? r.c2_block_count : 16'd0;
    eff = ({4'd0, r.c2_pointer_bits} > c2b) ? {4'd0, r.c2_pointer_bits} : c2b;
    // first sector of a second opens a fresh window
    if (second_pos == 7'd0) begin
      second_base = r.sector_address;
      second_c1 = '0;
      second_c2 = '0;
    end
    if (!r.read_ok) begin
      tally.read_failure_count = sat_add24(tally.read_failure_count, 24'd1);
      lengthen_run();
    end else begin
      if (c1 != 16'd0) begin
        tally.c1_total = sat_add32(tally.c1_total, {16'd0, c1});
        tally.c1_sector_count = sat_add24(tally.c1_sector_count, 24'd1);
        second_c1 = sat_add24(second_c1, {8'd0, c1});
        if (c1 > tally.c1_sector_peak) tally.c1_sector_peak = c1;
        if (second_c1 > tally.c1_second_peak) tally.c1_second_peak = second_c1;
      end
      if (eff != 16'd0 && r.sense_key != RECOVERED_KEY) begin
        tally.c2_total = sat_add32(tally.c2_total, {16'd0, eff});
        tally.c2_sector_count = sat_add24(tally.c2_sector_count, 24'd1);
        second_c2 = sat_add24(second_c2, {8'd0, eff});
        // strict compares: the first sector or second to reach a peak keeps it
        if (eff > tally.c2_sector_peak) begin
          tally.c2_sector_peak = eff;
          tally.c2_peak_address = r.sector_address;
        end
        if (second_c2 > tally.c2_second_peak) begin
          tally.c2_second_peak = second_c2;
          tally.c2_second_address = second_base;
        end
        lengthen_run();
      end else begin
        run_len = '0;
      end
    end
    if (int'(second_pos) + 1 >= SECTORS_PER_SECOND) second_pos = '0;
    else second_pos = second_pos + 7'd1;
    return tally;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  function automatic int pick_gap(logic idle_on);
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Monitor and tracker: take input beats and result beats at the rising edge.
  always @(posedge clk) begin
    cycle_cnt++;
    in_taken = 1'b0;
    if (rst) begin
      c1_enable_model = 1'b1;
      clear_tallies();
      expected_stats.delete();
    end else begin
      if (cfg_valid && cfg_ready) c1_enable_model = cfg_data;
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        sectors_in++;
        expected_stats.insert(expected_stats.size(),
          count_sector(s_tuser[0], sector_rep_t'(s_tdata[$bits(sector_rep_t)-1:0])));
      end
      if (m_tvalid && m_tready) begin
        if (expected_stats.size() == 0) begin
          $error("result beat with no sector pending");
          mismatches++;
        end else begin
          want_stats = expected_stats.pop_front();
          got_stats = sector_stats_t'(m_tdata);
          check_field("c1_total", want_stats.c1_total, got_stats.c1_total);
          check_field("c1_sector_count", 32'(want_stats.c1_sector_count),
                      32'(got_stats.c1_sector_count));
          check_field("c1_sector_peak", 32'(want_stats.c1_sector_peak),
                      32'(got_stats.c1_sector_peak));
          check_field("c1_second_peak", 32'(want_stats.c1_second_peak),
                      32'(got_stats.c1_second_peak));
          check_field("c2_total", want_stats.c2_total, got_stats.c2_total);
          check_field("c2_sector_count", 32'(want_stats.c2_sector_count),
                      32'(got_stats.c2_sector_count));
          check_field("c2_sector_peak", 32'(want_stats.c2_sector_peak),
                      32'(got_stats.c2_sector_peak));
          check_field("c2_peak_address", 32'(want_stats.c2_peak_address),
                      32'(got_stats.c2_peak_address));
          check_field("c2_second_peak", 32'(want_stats.c2_second_peak),
                      32'(got_stats.c2_second_peak));
          check_field("c2_second_address", 32'(want_stats.c2_second_address),
                      32'(got_stats.c2_second_address));
          check_field("read_failure_count", 32'(want_stats.read_failure_count),
                      32'(got_stats.read_failure_count));
          check_field("longest_error_run", 32'(want_stats.longest_error_run),
                      32'(got_stats.longest_error_run));
        end
      end
    end
  end

  // Sector driver: advance to the next beat once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (src_gap > 0 || pending_sectors.size() == 0) begin
        if (src_gap > 0) src_gap--;
        s_tvalid <= 1'b0;
      end else begin
        next_beat = pending_sectors.pop_front();
        s_tdata <= IN_W'(next_beat.rep);
        s_tuser <= next_beat.start_scan;
        s_tvalid <= 1'b1;
        src_gap = pick_gap(src_idle_on);
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_off_done && sectors_in >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        sink_stall = HOLD_OFF_CYCLES;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_stall = pick_gap(snk_idle_on);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic add_sector(logic start, logic [23:0] addr, logic ok, logic [3:0] key,
                            logic [11:0] ptr, logic [15:0] c1, logic [15:0] c2b);
    sector_beat_t b;
    b.start_scan = start;
    b.rep.sector_address = addr;
    b.rep.read_ok = ok;
    b.rep.sense_key = key;
    b.rep.c2_pointer_bits = ptr;
    b.rep.c1_block_count = c1;
    b.rep.c2_block_count = c2b;
    pending_sectors.insert(pending_sectors.size(), b);
  endtask

  function automatic sector_beat_t noise_sector();
    sector_beat_t b;
    b.start_scan = ($urandom_range(7) == 0);
    b.rep.sector_address = 24'($urandom);
    b.rep.read_ok = 1'($urandom);
    b.rep.sense_key = 4'($urandom);
    b.rep.c2_pointer_bits = 12'($urandom);
    b.rep.c1_block_count = 16'($urandom);
    b.rep.c2_block_count = 16'($urandom);
    return b;
  endfunction

  // Mostly clean sectors with light C1, sparse C2 and occasional error bursts.
  function automatic sector_rep_t scan_sector(logic [23:0] addr);
    sector_rep_t r;
    int roll;
    r.sector_address = addr;
    r.read_ok = 1'b1;
    r.sense_key = ($urandom_range(3) == 0) ? RECOVERED_KEY : 4'($urandom_range(15));
    roll = $urandom_range(99);
    r.c1_block_count = (roll < 40) ? 16'd0 :
                       (roll < 90) ? 16'($urandom_range(60, 1)) : 16'($urandom);
    roll = $urandom_range(99);
    r.c2_pointer_bits = (roll < 75) ? 12'd0 :
                        (roll < 95) ? 12'($urandom_range(300, 1)) : 12'($urandom);
    roll = $urandom_range(99);
    r.c2_block_count = (roll < 80) ? 16'd0 :
                       (roll < 95) ? 16'($urandom_range(50, 1)) : 16'($urandom);
    if (burst_left > 0) begin
      burst_left--;
      if ($urandom_range(1) == 0) begin
        r.read_ok = 1'b0;
      end else begin
        if (r.sense_key == RECOVERED_KEY) r.sense_key = NO_SENSE;
        r.c2_pointer_bits = 12'($urandom_range(2352, 1));
      end
    end else if ($urandom_range(39) == 0) begin
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(100, 13) : $urandom_range(12, 1);
    end else if ($urandom_range(99) == 0) begin
      r.read_ok = 1'b0;
    end
    return r;
  endfunction

  task automatic queue_random_sectors(int total);
    int made;
    int len;
    int kind;
    logic [23:0] addr;
    sector_beat_t b;
    made = 0;
    while (made < total) begin
      kind = $urandom_range(9);
      // scans with a start, a few continuing without one, the rest noise
      if (kind >= 8) len = $urandom_range(8, 1);
      else if ($urandom_range(7) == 0) len = $urandom_range(400, 150);
      else len = $urandom_range(160, 5);
      if (len > total - made) len = total - made;
      addr = 24'($urandom);
      for (int i = 0; i < len; i++) begin
        if (kind >= 8) begin
          b = noise_sector();
        end else begin
          b.start_scan = (i == 0 && kind < 7);
          b.rep = scan_sector(addr);
        end
        pending_sectors.insert(pending_sectors.size(), b);
        addr = addr + 24'd1;
      end
      made += len;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_sectors.size() != 0 || s_tvalid || m_tvalid ||
           expected_stats.size() != 0);
  endtask

  task automatic write_c1_enable(logic en);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= en;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_c1_enable(1'b1);
    add_sector(1'b1, 24'h000000, 1'b1, NO_SENSE, 12'd0, 16'd0, 16'd0);
    add_sector(1'b0, 24'h000001, 1'b1, NO_SENSE, 12'd0, 16'hFFFF, 16'd0);
    add_sector(1'b0, 24'h000002, 1'b1, NO_SENSE, 12'd2352, 16'd1, 16'd0);
    // recovered: C1 still counts, C2 does not, run breaks
    add_sector(1'b0, 24'h000003, 1'b1, RECOVERED_KEY, 12'hFFF, 16'd5, 16'hFFFF);
    // failed reads add nothing to C1/C2 but extend the run
    add_sector(1'b0, 24'h000004, 1'b0, 4'hF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    add_sector(1'b0, 24'h000005, 1'b0, 4'h3, 12'd0, 16'd0, 16'd0);
    add_sector(1'b0, 24'h000006, 1'b1, 4'h3, 12'd100, 16'd0, 16'd200);
    add_sector(1'b0, 24'h000007, 1'b1, 4'hF, 12'hFFF, 16'd0, 16'd0);
    // tie on the C2 peak keeps the earlier address
    add_sector(1'b0, 24'h000008, 1'b1, NO_SENSE, 12'd0, 16'd0, 16'd4095);
    add_sector(1'b0, 24'h000009, 1'b1, NO_SENSE, 12'd0, 16'd0, 16'hFFFF);
    add_sector(1'b0, 24'hFFFFFF, 1'b1, 4'h2, 12'd0, 16'd0, 16'd0);
    add_sector(1'b1, 24'hFFFFFF, 1'b1, 4'h4, 12'd1, 16'd1, 16'd0);
    add_sector(1'b0, 24'h000000, 1'b1, NO_SENSE, 12'd0, 16'd0, 16'hFFFF);
    wait_drained();

    // block counts ignored while C1 reporting is off
    write_c1_enable(1'b0);
    add_sector(1'b1, 24'h123456, 1'b1, NO_SENSE, 12'd0, 16'hFFFF, 16'hFFFF);
    add_sector(1'b0, 24'h123457, 1'b1, NO_SENSE, 12'd2352, 16'd100, 16'hFFFF);
    add_sector(1'b0, 24'h123458, 1'b0, RECOVERED_KEY, 12'd7, 16'd9, 16'd9);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      write_c1_enable((phase % 2) == 0);
      // first phase runs the sender flat out against the long sink hold-off
      src_idle_on = (phase != 0 && phase != 3);
      snk_idle_on = (phase != 3);
      queue_random_sectors(300);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/cdses_pkg.sv
src/cd_sector_error_statistics.sv
src/cdses_checker.sv
verif/tb_cd_sector_error_statistics.sv
